FILE: rtl/core/clnbw_pkg.sv
package clnbw_pkg;

  // Input item kinds
  typedef enum logic [1:0] {
    ITEM_INIT  = 2'd0,
    ITEM_BEGIN = 2'd1,
    ITEM_CHAR  = 2'd2,
    ITEM_CLEAR = 2'd3
  } item_kind_e;

  // Work handed from the front to the back
  typedef enum logic [2:0] {
    JOB_INIT,
    JOB_BEGIN,
    JOB_CLEAR,
    JOB_NEWLINE,
    JOB_DATA,
    JOB_DATA_WRAP
  } job_kind_e;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] char_code;
  } item_t;

  typedef struct packed {
    logic [7:0] expander_byte;
    logic       last;
  } result_t;

  typedef struct packed {
    job_kind_e  kind;
    logic [7:0] data;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } job_push_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } job_head_t;

  localparam logic [7:0] CHAR_END     = 8'h00;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

  localparam logic [3:0] WAKE_NIBBLE      = 4'h3;
  localparam logic [3:0] FOUR_BIT_NIBBLE  = 4'h2;
  localparam logic [7:0] CMD_FUNCTION_SET = 8'h28;
  localparam logic [7:0] CMD_DISPLAY_ON   = 8'h0C;
  localparam logic [7:0] CMD_CLEAR        = 8'h01;
  localparam logic [7:0] CMD_ENTRY_MODE   = 8'h06;
  localparam logic [7:0] CMD_CURSOR_ROW0  = 8'h80;
  localparam logic [7:0] CMD_CURSOR_ROW1  = 8'h80 | 8'h40;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;
  localparam int unsigned QCNT_W      = 3;

  // Index of the final nibble of each job
  function automatic logic [3:0] job_last_idx(job_kind_e kind);
    logic [3:0] n;
    n = 4'd1;
    case (kind)
      JOB_INIT:      n = 4'd13;
      JOB_BEGIN:     n = 4'd5;
      JOB_DATA_WRAP: n = 4'd3;
      default:       n = 4'd1;
    endcase
    return n;
  endfunction

  // Returns {register_select, nibble} for nibble idx of a job
  function automatic logic [4:0] job_nibble(job_kind_e kind, logic [7:0] data,
                                            logic [3:0] idx);
    logic [7:0] val;
    logic       rs;
    logic       raw;
    logic [3:0] raw_nib;
    val     = CMD_CLEAR;
    rs      = 1'b0;
    raw     = 1'b0;
    raw_nib = WAKE_NIBBLE;
    case (kind)
      JOB_INIT: begin
        if (idx < 4'd4) begin
          raw     = 1'b1;
          raw_nib = (idx == 4'd3) ? FOUR_BIT_NIBBLE : WAKE_NIBBLE;
        end else begin
          case (idx[3:1])
            3'd2:    val = CMD_FUNCTION_SET;
            3'd3:    val = CMD_DISPLAY_ON;
            3'd4:    val = CMD_CLEAR;
            3'd5:    val = CMD_ENTRY_MODE;
            default: val = CMD_CURSOR_ROW0;
          endcase
        end
      end
      JOB_BEGIN:   val = (idx[3:1] == 3'd0) ? CMD_CLEAR : CMD_CURSOR_ROW0;
      JOB_CLEAR:   val = CMD_CLEAR;
      JOB_NEWLINE: val = CMD_CURSOR_ROW1;
      JOB_DATA: begin
        val = data;
        rs  = 1'b1;
      end
      JOB_DATA_WRAP: begin
        if (idx[1] == 1'b0) begin
          val = data;
          rs  = 1'b1;
        end else begin
          val = CMD_CURSOR_ROW1;
        end
      end
      default: val = CMD_CLEAR;
    endcase
    if (raw) begin
      return {rs, raw_nib};
    end
    return {rs, (idx[0] ? val[3:0] : val[7:4])};
  endfunction

endpackage

FILE: rtl/core/char_lcd_nibble_bus_writer_core.sv
// A taken item is registered in the job queue before the back end loads its first byte.
// One expander byte per cycle while result_ready holds; an item yields 4 to 28 bytes,
// set by the nibble sequencer in the back end; an item with no bytes queues no job.
// A four-entry job queue lets the front take items while the back end is still sending.
// Reset (synchronous, rst high) homes the cursor, clears the message counters,
// empties the queue and output register, and turns the backlight bit on.
module char_lcd_nibble_bus_writer_core
  import clnbw_pkg::*;
#(
  parameter int unsigned LINE_LENGTH = 16,
  parameter int unsigned MAX_MESSAGE = 80
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    cfg_write,
  input  logic    cfg_data,
  input  logic    item_valid,
  output logic    item_ready,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  job_push_t push;
  job_head_t head;
  logic      queue_full;
  logic      pop;

  clnbw_front #(
    .LINE_LENGTH (LINE_LENGTH),
    .MAX_MESSAGE (MAX_MESSAGE)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .queue_full (queue_full),
    .push       (push)
  );

  clnbw_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (queue_full),
    .head (head),
    .pop  (pop)
  );

  clnbw_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .head         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

FILE: rtl/core/clnbw_front.sv
module clnbw_front
  import clnbw_pkg::*;
#(
  parameter int unsigned LINE_LENGTH = 16,
  parameter int unsigned MAX_MESSAGE = 80
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_ready,
  input  item_t     item,
  input  logic      queue_full,
  output job_push_t push
);

  localparam int unsigned COL_W   = $clog2(LINE_LENGTH + 1);
  localparam int unsigned TAKEN_W = $clog2(MAX_MESSAGE + 1);

  logic               cursor_row, cursor_row_next;
  logic [COL_W-1:0]   cursor_column, cursor_column_next;
  logic [TAKEN_W-1:0] chars_taken, chars_taken_next;
  logic               message_ended, message_ended_next;

  logic               accept;
  logic [COL_W-1:0]   col_inc;

  assign item_ready = !queue_full;
  assign accept     = item_valid && item_ready;

  always_comb begin
    cursor_row_next    = cursor_row;
    cursor_column_next = cursor_column;
    chars_taken_next   = chars_taken;
    message_ended_next = message_ended;
    push.valid         = 1'b0;
    push.job.kind      = JOB_CLEAR;
    push.job.data      = item.char_code;
    col_inc = (cursor_column < COL_W'(LINE_LENGTH)) ? cursor_column + 1'b1
                                                    : cursor_column;
    if (accept) begin
      case (item_kind_e'(item.kind))
        ITEM_INIT: begin
          cursor_row_next    = 1'b0;
          cursor_column_next = '0;
          push.valid         = 1'b1;
          push.job.kind      = JOB_INIT;
        end
        ITEM_BEGIN: begin
          cursor_row_next    = 1'b0;
          cursor_column_next = '0;
          chars_taken_next   = '0;
          message_ended_next = 1'b0;
          push.valid         = 1'b1;
          push.job.kind      = JOB_BEGIN;
        end
        ITEM_CLEAR: begin
          push.valid    = 1'b1;
          push.job.kind = JOB_CLEAR;
        end
        ITEM_CHAR: begin
          // drop characters after the end or past the message limit
          if (!message_ended && chars_taken < TAKEN_W'(MAX_MESSAGE)) begin
            chars_taken_next = chars_taken + 1'b1;
            if (item.char_code == CHAR_END) begin
              message_ended_next = 1'b1;
            end else if (item.char_code == CHAR_NEWLINE) begin
              cursor_row_next    = 1'b1;
              cursor_column_next = '0;
              push.valid         = 1'b1;
              push.job.kind      = JOB_NEWLINE;
            end else if (col_inc >= COL_W'(LINE_LENGTH) && !cursor_row) begin
              cursor_row_next    = 1'b1;
              cursor_column_next = '0;
              push.valid         = 1'b1;
              push.job.kind      = JOB_DATA_WRAP;
            end else begin
              cursor_column_next = col_inc;
              push.valid         = 1'b1;
              push.job.kind      = JOB_DATA;
            end
          end
        end
        default: push.valid = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_row    <= 1'b0;
      cursor_column <= '0;
      chars_taken   <= '0;
      message_ended <= 1'b0;
    end else begin
      cursor_row    <= cursor_row_next;
      cursor_column <= cursor_column_next;
      chars_taken   <= chars_taken_next;
      message_ended <= message_ended_next;
    end
  end

  a_column_bound: assert property (@(posedge clk) disable iff (rst)
    cursor_column <= COL_W'(LINE_LENGTH))
    else $error("cursor column past line length");

  a_row0_no_full_line: assert property (@(posedge clk) disable iff (rst)
    !cursor_row |-> cursor_column < COL_W'(LINE_LENGTH))
    else $error("row 0 holds a full line without wrapping");

endmodule

FILE: rtl/core/clnbw_queue.sv
module clnbw_queue
  import clnbw_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  job_push_t push,
  output logic      full,
  output job_head_t head,
  input  logic      pop
);

  job_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full       = (count == QCNT_W'(QUEUE_DEPTH));
  assign head.valid = (count != '0);
  assign head.job   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push.valid && !full) begin
      entries[wr_ptr] <= push.job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.valid && !full) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop && head.valid) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + QCNT_W'(push.valid && !full) - QCNT_W'(pop && head.valid);
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> head.valid)
    else $error("pop from empty queue");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push.valid |-> !full)
    else $error("push into full queue");

endmodule

FILE: rtl/core/clnbw_back.sv
module clnbw_back
  import clnbw_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_write,
  input  logic      cfg_data,
  input  job_head_t head,
  output logic      pop,
  output logic      result_valid,
  input  logic      result_ready,
  output result_t   result
);

  logic       backlight_on;
  logic [3:0] nib_idx;
  logic       phase;      // 0: enable-high byte, 1: enable-low byte
  logic       load;
  logic       at_last_nib;
  logic [4:0] rs_nib;

  assign load        = head.valid && (!result_valid || result_ready);
  assign at_last_nib = (nib_idx == job_last_idx(head.job.kind));
  assign rs_nib      = job_nibble(head.job.kind, head.job.data, nib_idx);
  assign pop         = load && phase && at_last_nib;

  always_ff @(posedge clk) begin
    if (rst) begin
      backlight_on <= 1'b1;
    end else if (cfg_write) begin
      backlight_on <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result.expander_byte <= {rs_nib[3:0], backlight_on, ~phase, 1'b0, rs_nib[4]};
      result.last          <= phase && at_last_nib;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      nib_idx      <= '0;
      phase        <= 1'b0;
    end else begin
      if (load) begin
        result_valid <= 1'b1;
        phase        <= ~phase;
        // advance to the next nibble after its enable-low byte
        if (phase) begin
          nib_idx <= at_last_nib ? '0 : nib_idx + 1'b1;
        end
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  a_idx_in_job: assert property (@(posedge clk) disable iff (rst)
    head.valid |-> nib_idx <= job_last_idx(head.job.kind))
    else $error("nibble index past end of transaction");

  a_idle_at_start: assert property (@(posedge clk) disable iff (rst)
    !head.valid |-> (nib_idx == '0 && !phase))
    else $error("sequencer not at start while queue empty");

endmodule
